[hw/rtl/bdp_pkg.sv]
// bdp_pkg: shared types and constants for the debounced button block
// no dependencies; used by the interfaces, bdp_core and the top level
`default_nettype none

package bdp_pkg;

    localparam int unsigned MS_W    = 16;
    localparam int unsigned HELD_W  = 32;
    localparam int unsigned CFG_IDX_W = 8;

    typedef logic [MS_W-1:0]      ms_t;
    typedef logic [HELD_W-1:0]    held_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_LOCKOUT_MS       = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_DOUBLE_WINDOW_MS = cfg_idx_t'(1);

    localparam ms_t LOCKOUT_MS_RESET       = ms_t'(40);
    localparam ms_t DOUBLE_WINDOW_MS_RESET = ms_t'(250);

    typedef struct packed {
        logic pin_level;
        ms_t  elapsed_ms;
    } tick_t;

    typedef struct packed {
        logic  is_down;
        logic  press_pulse;
        logic  double_press;
        held_t held_time;
    } result_t;

    typedef struct packed {
        ms_t lockout_ms;
        ms_t double_window_ms;
    } cfg_t;

    function automatic ms_t sub_floor(input ms_t a, input ms_t b);
        sub_floor = (a > b) ? ms_t'(a - b) : '0;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bdp_if.sv]
// bdp_if: valid/ready channel interfaces for ticks, results and configuration writes
// depends on bdp_pkg
`default_nettype none

interface bdp_tick_if;
    logic             valid;
    logic             ready;
    logic             pin_level;
    bdp_pkg::ms_t     elapsed_ms;

    modport source (output valid, output pin_level, output elapsed_ms, input ready);
    modport sink   (input valid, input pin_level, input elapsed_ms, output ready);
endinterface

interface bdp_result_if;
    logic             valid;
    logic             ready;
    logic             is_down;
    logic             press_pulse;
    logic             double_press;
    bdp_pkg::held_t   held_time;

    modport source (output valid, output is_down, output press_pulse, output double_press,
                    output held_time, input ready);
    modport sink   (input valid, input is_down, input press_pulse, input double_press,
                    input held_time, output ready);
endinterface

interface bdp_cfg_if;
    logic               valid;
    logic               ready;
    bdp_pkg::cfg_idx_t  index;
    bdp_pkg::ms_t       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/button_debounce_double_press.sv]
// button_debounce_double_press: top level with tick register, result register and config
// depends on bdp_pkg, bdp_if and bdp_core
//
// Each tick transaction carries the raw active-low pin level and the milliseconds since
// the previous tick, and gives exactly one result transaction: debounced down flag, a
// press pulse on a debounced release, a double press flag when a second release comes
// within double_window_ms of the first, and the saturating held time. Each accepted tick
// is held in the tick register and its result in the result register; one tick can be
// taken every cycle, since bdp_core updates its state as the result is registered, and a
// stalled result stops the tick side only once both registers are full. Configuration
// writes (index 0 lockout_ms, index 1 double_window_ms, other indices ignored) are always
// accepted and must only be issued while no tick is in flight.
`default_nettype none

module button_debounce_double_press (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bdp_tick_if.sink      tick_in,
    bdp_result_if.source  result_out,
    bdp_cfg_if.sink       cfg
);
    import bdp_pkg::*;

    cfg_t    cfg_reg;
    logic    tick_valid_reg;
    tick_t   tick_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t core_result;
    logic    advance;
    logic    take_in;

    assign advance = tick_valid_reg && (!out_valid_reg || result_out.ready);
    assign take_in = tick_in.valid && tick_in.ready;

    assign tick_in.ready = !tick_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ms       <= LOCKOUT_MS_RESET;
            cfg_reg.double_window_ms <= DOUBLE_WINDOW_MS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LOCKOUT_MS:       cfg_reg.lockout_ms       <= cfg.data;
                CFG_DOUBLE_WINDOW_MS: cfg_reg.double_window_ms <= cfg.data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tick_in.ready)
                tick_valid_reg <= tick_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            tick_reg.pin_level  <= tick_in.pin_level;
            tick_reg.elapsed_ms <= tick_in.elapsed_ms;
        end
        if (advance)
            result_reg <= core_result;
    end

    bdp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (tick_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign result_out.valid        = out_valid_reg;
    assign result_out.is_down      = result_reg.is_down;
    assign result_out.press_pulse  = result_reg.press_pulse;
    assign result_out.double_press = result_reg.double_press;
    assign result_out.held_time    = result_reg.held_time;

    a_double_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.double_press |-> result_reg.press_pulse)
        else $error("double press reported without a press pulse");

    a_pulse_means_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.press_pulse |-> !result_reg.is_down)
        else $error("press pulse while still down");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready |-> !advance)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[hw/rtl/bdp_core.sv]
// bdp_core: debounce, held time and double press state with its one-tick update
// depends on bdp_pkg
`default_nettype none

module bdp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire bdp_pkg::tick_t   tick,
    input  wire bdp_pkg::cfg_t    cfg,
    output bdp_pkg::result_t      result
);
    import bdp_pkg::*;

    logic  down_flag_reg, down_flag_next;
    ms_t   lockout_count_reg, lockout_count_next;
    held_t press_time_reg, press_time_next;
    ms_t   double_count_reg, double_count_next;

    logic          pressed;
    logic          bypass;
    logic          pulse;
    logic          dbl;
    logic [HELD_W:0] held_sum;
    ms_t           double_dec;

    always_comb
    begin
        pressed  = ~tick.pin_level;
        bypass   = (tick.elapsed_ms >= cfg.lockout_ms);
        held_sum = {1'b0, press_time_reg} + {{(HELD_W + 1 - MS_W){1'b0}}, tick.elapsed_ms};

        down_flag_next     = down_flag_reg;
        lockout_count_next = lockout_count_reg;
        press_time_next    = press_time_reg;

        if (bypass)
        begin
            down_flag_next = pressed;
        end
        else
        begin
            if ((down_flag_reg != pressed) && (lockout_count_reg == '0))
            begin
                down_flag_next     = pressed;
                lockout_count_next = cfg.lockout_ms;
            end
            else
            begin
                lockout_count_next = sub_floor(lockout_count_reg, tick.elapsed_ms);
            end

            if (pressed)
                press_time_next = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];
            else
                press_time_next = '0;
        end

        // previous debounced level doubles as the last-down history
        pulse      = down_flag_reg & ~down_flag_next;
        double_dec = sub_floor(double_count_reg, tick.elapsed_ms);
        dbl        = 1'b0;
        double_count_next = double_dec;
        if (pulse)
        begin
            if (double_dec == '0)
                double_count_next = cfg.double_window_ms;
            else
            begin
                double_count_next = '0;
                dbl               = 1'b1;
            end
        end

        result.is_down      = down_flag_next;
        result.press_pulse  = pulse;
        result.double_press = dbl;
        result.held_time    = press_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_flag_reg     <= 1'b0;
            lockout_count_reg <= '0;
            press_time_reg    <= '0;
            double_count_reg  <= '0;
        end
        else if (step)
        begin
            down_flag_reg     <= down_flag_next;
            lockout_count_reg <= lockout_count_next;
            press_time_reg    <= press_time_next;
            double_count_reg  <= double_count_next;
        end
    end

    a_double_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        step && dbl |=> double_count_reg == '0)
        else $error("double press did not clear the window count");

    a_pulse_from_down: assert property (@(posedge clk) disable iff (!rst_n)
        step && pulse |-> down_flag_reg && !down_flag_next)
        else $error("press pulse without a falling debounced level");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(down_flag_reg) && $stable(press_time_reg)
                  && $stable(double_count_reg) && $stable(lockout_count_reg))
        else $error("state moved without a tick");

    a_released_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        step && !bypass && tick.pin_level |=> press_time_reg == '0)
        else $error("held time not cleared on a released lockout tick");

endmodule

`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for button_debounce_double_press, ticks in, one result per tick out
// depends on bdp_pkg, bdp_if and the block; a scoreboard class predicts and checks each result
`timescale 1ns / 100ps

module tb;
    import bdp_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_TICKS   = 215;
    localparam int unsigned HOLD_TICKS    = 40;
    localparam cfg_idx_t    CFG_SPARE     = cfg_idx_t'(2);
    localparam held_t       HELD_MAX      = '1;

    localparam ms_t LOCK_SET [6] = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd7, 16'd40};
    localparam ms_t WIN_SET  [6] = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd30, 16'd250};

    localparam tick_t DIRECTED [20] = '{
        {1'b1, 16'd0},     {1'b0, 16'd0},     {1'b0, 16'd10},    {1'b1, 16'd5},
        {1'b0, 16'd39},    {1'b1, 16'd39},    {1'b0, 16'd20},    {1'b0, 16'd20},
        {1'b0, 16'd1},     {1'b1, 16'd39},    {1'b1, 16'd1},     {1'b1, 16'd0},
        {1'b0, 16'd40},    {1'b1, 16'hFFFF},  {1'b0, 16'hFFFF},  {1'b1, 16'hFFFF},
        {1'b0, 16'h5555},  {1'b1, 16'hAAAA},  {1'b0, 16'd0},     {1'b1, 16'd0}
    };

    class press_scoreboard;
        ms_t         lockout_ms;
        ms_t         window_ms;
        logic        down;
        logic        was_down;
        ms_t         lock_left;
        ms_t         window_left;
        held_t       held_ms;
        result_t     due_q[$];
        int unsigned errors;

        function new();
            lockout_ms  = LOCKOUT_MS_RESET;
            window_ms   = DOUBLE_WINDOW_MS_RESET;
            down        = 1'b0;
            was_down    = 1'b0;
            lock_left   = '0;
            window_left = '0;
            held_ms     = '0;
            errors      = 0;
        endfunction

        function ms_t count_down(ms_t a, ms_t b);
            return (a > b) ? ms_t'(a - b) : '0;
        endfunction

        function void apply_reg(cfg_idx_t idx, ms_t value);
            case (idx)
                CFG_LOCKOUT_MS:       lockout_ms = value;
                CFG_DOUBLE_WINDOW_MS: window_ms  = value;
                default: ;
            endcase
        endfunction

        function result_t debounce_step(tick_t t);
            result_t r;
            logic    pressed;
            logic    pulse;
            logic    dbl;
            pressed = ~t.pin_level;
            dbl     = 1'b0;
            if (t.elapsed_ms >= lockout_ms)
            begin
                down = pressed;
            end
            else if (pressed)
            begin
                if (!down && lock_left == '0)
                begin
                    down      = 1'b1;
                    lock_left = lockout_ms;
                end
                else
                begin
                    lock_left = count_down(lock_left, t.elapsed_ms);
                end
                if (held_ms > HELD_MAX - held_t'(t.elapsed_ms))
                    held_ms = HELD_MAX;
                else
                    held_ms = held_ms + held_t'(t.elapsed_ms);
            end
            else
            begin
                if (down && lock_left == '0)
                begin
                    down      = 1'b0;
                    lock_left = lockout_ms;
                end
                else
                begin
                    lock_left = count_down(lock_left, t.elapsed_ms);
                end
                held_ms = '0;
            end
            pulse       = was_down && !down;
            was_down    = down;
            window_left = count_down(window_left, t.elapsed_ms);
            if (pulse)
            begin
                if (window_left == '0)
                    window_left = window_ms;
                else
                begin
                    window_left = '0;
                    dbl         = 1'b1;
                end
            end
            r.is_down      = down;
            r.press_pulse  = pulse;
            r.double_press = dbl;
            r.held_time    = held_ms;
            return r;
        endfunction

        function void note_tick(tick_t t);
            due_q.push_back(debounce_step(t));
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("tb: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (due_q.size() == 0)
            begin
                report("result transaction with nothing pending");
                return;
            end
            want = due_q.pop_front();
            if (got.is_down !== want.is_down)
                report($sformatf("is_down got %b want %b", got.is_down, want.is_down));
            if (got.press_pulse !== want.press_pulse)
                report($sformatf("press_pulse got %b want %b",
                                 got.press_pulse, want.press_pulse));
            if (got.double_press !== want.double_press)
                report($sformatf("double_press got %b want %b",
                                 got.double_press, want.double_press));
            if (got.held_time !== want.held_time)
                report($sformatf("held_time got %0h want %0h", got.held_time, want.held_time));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bdp_tick_if   tick_ch();
    bdp_result_if res_ch();
    bdp_cfg_if    cfg_ch();

    press_scoreboard sb;
    int unsigned     burst_left;
    bit              calm;
    int unsigned     rx_count = 0;
    int unsigned     rx_mode  = 0;

    button_debounce_double_press u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_in    (tick_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver stall pattern in one of four randomly chosen modes
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            rx_count++;
            if (rx_count % 400 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       res_ch.ready <= (rx_count % 5 != 0);
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                sb.note_tick(tick_t'{tick_ch.pin_level, tick_ch.elapsed_ms});
            if (res_ch.valid === 1'b1 && res_ch.ready)
                sb.check_result(result_t'{res_ch.is_down, res_ch.press_pulse,
                                          res_ch.double_press, res_ch.held_time});
        end
    end

    task automatic send_tick(input logic pin, input ms_t dt);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        tick_ch.valid      <= 1'b1;
        tick_ch.pin_level  <= pin;
        tick_ch.elapsed_ms <= dt;
        do @(posedge clk); while (tick_ch.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.due_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input ms_t value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.apply_reg(idx, value);
    endtask

    // mostly inside the lockout so the counter matters, some at or past the threshold
    function automatic ms_t pick_elapsed();
        ms_t         lim;
        int unsigned sel;
        lim = (sb.lockout_ms > 0) ? ms_t'(sb.lockout_ms - 1) : '0;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return ms_t'($urandom);
            1:       return sb.lockout_ms;
            2:       return lim;
            3:       return '0;
            default: return ms_t'($urandom_range(0, lim >> $urandom_range(0, 4)));
        endcase
    endfunction

    // steady presses and releases with short bounces, plus some noise
    task automatic run_phase(input int unsigned n_ticks);
        logic        pin;
        int unsigned run_left;
        pin      = 1'b1;
        run_left = 0;
        calm     = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < n_ticks; i++)
        begin
            if (run_left == 0)
            begin
                pin      = ~pin;
                run_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2)
                                                       : $urandom_range(3, 20);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0)
                send_tick(1'($urandom_range(0, 1)), ms_t'($urandom));
            else
                send_tick(pin, pick_elapsed());
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb                 = new();
        burst_left         = 0;
        calm               = 1'b1;
        rst_n              <= 1'b0;
        tick_ch.valid      <= 1'b0;
        tick_ch.pin_level  <= 1'b1;
        tick_ch.elapsed_ms <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_LOCKOUT_MS;
        cfg_ch.data        <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_tick(DIRECTED[i].pin_level, DIRECTED[i].elapsed_ms);

        // unused index must leave both registers alone
        write_reg(CFG_SPARE, 16'h0003);
        run_phase(PHASE_TICKS / 2);

        foreach (LOCK_SET[i])
        begin
            write_reg(CFG_LOCKOUT_MS, LOCK_SET[i]);
            write_reg(CFG_DOUBLE_WINDOW_MS, WIN_SET[i]);
            run_phase(PHASE_TICKS);
        end

        // long press inside the lockout with large steps of held time
        write_reg(CFG_LOCKOUT_MS, 16'hFFFF);
        calm = 1'b1;
        send_tick(1'b0, 16'd0);
        for (int unsigned i = 0; i < HOLD_TICKS; i++)
            send_tick(1'b0, 16'hFFFE);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'd0);

        repeat (2)
        begin
            write_reg(CFG_LOCKOUT_MS, ms_t'($urandom_range(1, 300)));
            write_reg(CFG_DOUBLE_WINDOW_MS, ms_t'($urandom_range(1, 65535)));
            run_phase(PHASE_TICKS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("tb: done, errors");
        $finish;
    end

endmodule
